// ===== design/assert_macros.svh =====
// Assertion macros used by the top level of the speed ramp frame generator.
// No dependencies; each user module must provide clk and rst_n.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, disabled while reset is held.
`define ASSERT_IMPL(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, disabled while reset is held.
`define ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ===== design/srmfg_pkg.sv =====
// Shared types and constants for the speed ramp Modbus frame generator.
// No dependencies; imported by srmfg_crc and the top level.
package srmfg_pkg;

    localparam int SPEED_W    = 15;
    localparam int STEP_W     = 10;
    localparam int WORD_W     = 16;
    localparam int BYTE_W     = 8;
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 16;
    localparam int MAX_FRAMES = 50;
    localparam int FRAME_CNT_W = 6;
    localparam int NUM_BYTES  = 6;
    localparam int BYTE_CNT_W = 3;

    // Configuration register indexes.
    localparam logic [CFG_IDX_W-1:0] CFG_SPEED_LIMIT   = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_START_SPEED   = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_RAMP_STEP     = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_RUN_WORD      = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_BRAKE_WORD    = 3'd4;
    localparam logic [CFG_IDX_W-1:0] CFG_SLAVE_ADDRESS = 3'd5;

    // Reset values of the configuration registers.
    localparam logic [SPEED_W-1:0] RST_SPEED_LIMIT   = 15'd1200;
    localparam logic [SPEED_W-1:0] RST_START_SPEED   = 15'd250;
    localparam logic [STEP_W-1:0]  RST_RAMP_STEP     = 10'd20;
    localparam logic [WORD_W-1:0]  RST_RUN_WORD      = 16'h020B;
    localparam logic [WORD_W-1:0]  RST_BRAKE_WORD    = 16'h020F;
    localparam logic [BYTE_W-1:0]  RST_SLAVE_ADDRESS = 8'h01;

    // Modbus frame constants.
    localparam logic [BYTE_W-1:0] FUNC_WRITE  = 8'h06;
    localparam logic [BYTE_W-1:0] REG_HIGH    = 8'h80;
    localparam logic [BYTE_W-1:0] REG_CONTROL = 8'h00;
    localparam logic [BYTE_W-1:0] REG_SPEED   = 8'h05;
    localparam logic [WORD_W-1:0] CRC_INIT    = 16'hFFFF;
    localparam logic [WORD_W-1:0] CRC_POLY    = 16'hA001;

    // Request handed to the CRC engine when a frame is built.
    typedef struct packed {
        logic              start;
        logic [BYTE_W-1:0] slave_address;
        logic [BYTE_W-1:0] reg_index;
        logic [WORD_W-1:0] value;
    } crc_req_t;

endpackage

// ===== design/srmfg_crc.sv =====
// Byte-serial Modbus CRC16 engine: one frame byte folded in per cycle.
// Depends on srmfg_pkg.
module srmfg_crc (
    input  logic                             clk,
    input  logic                             rst_n,
    input  srmfg_pkg::crc_req_t              req,
    output logic                             done,
    output logic [srmfg_pkg::WORD_W-1:0]     crc
);
    import srmfg_pkg::*;

    logic                  busy_reg, busy_next;
    logic                  done_reg, done_next;
    logic [BYTE_CNT_W-1:0] cnt_reg, cnt_next;
    logic [WORD_W-1:0]     crc_reg, crc_next;
    logic [BYTE_W-1:0]     addr_reg, idx_reg;
    logic [WORD_W-1:0]     value_reg;
    logic [BYTE_W-1:0]     cur_byte;

    // Eight reflected shift steps of the polynomial for one byte.
    function automatic logic [WORD_W-1:0] crc_byte(input logic [WORD_W-1:0] crc_in,
                                                   input logic [BYTE_W-1:0] data_byte);
        logic [WORD_W-1:0] c;
        c = crc_in ^ {8'h00, data_byte};
        for (int i = 0; i < BYTE_W; i++) begin
            if (c[0])
                c = (c >> 1) ^ CRC_POLY;
            else
                c = c >> 1;
        end
        return c;
    endfunction

    always_comb
    begin
        case (cnt_reg)
            3'd0:    cur_byte = addr_reg;
            3'd1:    cur_byte = FUNC_WRITE;
            3'd2:    cur_byte = REG_HIGH;
            3'd3:    cur_byte = idx_reg;
            3'd4:    cur_byte = value_reg[7:0];
            3'd5:    cur_byte = value_reg[15:8];
            default: cur_byte = '0;
        endcase
    end

    always_comb
    begin
        busy_next = busy_reg;
        done_next = 1'b0;
        cnt_next  = cnt_reg;
        crc_next  = crc_reg;
        if (req.start)
        begin
            busy_next = 1'b1;
            cnt_next  = '0;
            crc_next  = CRC_INIT;
        end
        else if (busy_reg)
        begin
            crc_next = crc_byte(crc_reg, cur_byte);
            cnt_next = cnt_reg + 1'b1;
            if (cnt_reg == BYTE_CNT_W'(NUM_BYTES - 1))
            begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            cnt_reg  <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        crc_reg <= crc_next;
        if (req.start)
        begin
            addr_reg  <= req.slave_address;
            idx_reg   <= req.reg_index;
            value_reg <= req.value;
        end
    end

    assign done = done_reg;
    assign crc  = crc_reg;

endmodule

// ===== design/speed_ramp_modbus_frame_gen_top.sv =====
// Speed ramp Modbus RTU frame generator, top level. Depends on srmfg_pkg, srmfg_crc.
// One target word yields zero to fifty frame words. Each frame passes through a planning
// step, the CRC state (the engine folds in the six frame bytes, then its result is
// loaded) and the presenting state, plus any wait on m_tready. A rise from a nonzero
// speed first passes through the first and rise planning modes, which may emit no frame.
// s_tready is high only while the block is idle; a nonzero target whose clamp equals the
// kept speed returns to idle from planning without a frame. Reset (rst_n low, asynchronous)
// loads the configuration defaults and clears the kept speed and all control state.
`include "assert_macros.svh"

module speed_ramp_modbus_frame_gen_top (
    input  logic                                 clk,
    input  logic                                 rst_n,
    // Input stream: tdata = target_speed[15:0] (signed).
    input  logic                                 s_tvalid,
    output logic                                 s_tready,
    input  logic [15:0]                          s_tdata,
    // Output stream: tdata = register_index[7:0], register_value[23:8],
    // frame_crc[39:24]; tlast = last_frame.
    output logic                                 m_tvalid,
    input  logic                                 m_tready,
    output logic [39:0]                          m_tdata,
    output logic                                 m_tlast,
    // Configuration write port.
    input  logic                                 cfg_we,
    input  logic [srmfg_pkg::CFG_IDX_W-1:0]      cfg_index,
    input  logic [srmfg_pkg::CFG_DATA_W-1:0]     cfg_data
);
    import srmfg_pkg::*;

    // Main sequencer: wait for a word, plan the next frame, run the CRC, present it.
    typedef enum logic [3:0] {
        S_IDLE = 4'b0001,
        S_PLAN = 4'b0010,
        S_CRC  = 4'b0100,
        S_SEND = 4'b1000
    } state_t;

    // Which part of the command the planner is working on.
    typedef enum logic [2:0] {
        MODE_FIRST = 3'b001,
        MODE_RISE  = 3'b010,
        MODE_RAMP  = 3'b100
    } mode_t;

    state_t state_reg, state_next;
    mode_t  mode_reg, plan_mode;

    // Configuration registers.
    logic [SPEED_W-1:0] speed_limit_reg;
    logic [SPEED_W-1:0] start_speed_reg;
    logic [STEP_W-1:0]  ramp_step_reg;
    logic [WORD_W-1:0]  run_word_reg;
    logic [WORD_W-1:0]  brake_word_reg;
    logic [BYTE_W-1:0]  slave_address_reg;

    // Command state.
    logic [SPEED_W-1:0]     last_speed_reg;
    logic [WORD_W-1:0]      ramp_speed_reg;
    logic [SPEED_W-1:0]     target_reg;
    logic [SPEED_W-1:0]     cur_reg, plan_cur;
    logic [FRAME_CNT_W-1:0] n_reg;

    // Frame being built or presented.
    logic [BYTE_W-1:0] frame_idx_reg;
    logic [WORD_W-1:0] frame_val_reg;
    logic              frame_last_reg;
    logic [WORD_W-1:0] frame_crc_reg;
    logic              out_valid_reg;

    logic [SPEED_W-1:0] clamped;
    logic [SPEED_W-1:0] step_eff;
    logic [WORD_W-1:0]  ramp_sum;
    logic [SPEED_W-1:0] ramp_next;
    logic [SPEED_W-1:0] jump_speed;

    logic              plan_emit;
    logic              plan_finish;
    logic [BYTE_W-1:0] plan_idx;
    logic [WORD_W-1:0] plan_val;
    logic              plan_last;

    logic              in_accept;
    logic              out_accept;
    crc_req_t          crc_req;
    logic              crc_done;
    logic [WORD_W-1:0] crc_value;

    assign in_accept  = s_tvalid && s_tready;
    assign out_accept = m_tvalid && m_tready;

    // Negative targets clamp to zero, large ones to the configured limit.
    always_comb
    begin
        if (s_tdata[15])
            clamped = '0;
        else if (s_tdata[14:0] > speed_limit_reg)
            clamped = speed_limit_reg;
        else
            clamped = s_tdata[14:0];
    end

    // A zero step register behaves as a step of one.
    assign step_eff   = (ramp_step_reg == '0) ? SPEED_W'(1) : SPEED_W'(ramp_step_reg);
    assign ramp_sum   = {1'b0, cur_reg} + {1'b0, step_eff};
    assign jump_speed = (start_speed_reg < target_reg) ? start_speed_reg : target_reg;

    // The frame budget forces the fiftieth frame straight to the target.
    always_comb
    begin
        if ((n_reg >= FRAME_CNT_W'(MAX_FRAMES - 1)) || (ramp_sum >= {1'b0, target_reg}))
            ramp_next = target_reg;
        else
            ramp_next = ramp_sum[SPEED_W-1:0];
    end

    // Frame planner: decides the next frame of the current command, if any.
    always_comb
    begin
        plan_emit   = 1'b0;
        plan_finish = 1'b0;
        plan_idx    = REG_SPEED;
        plan_val    = '0;
        plan_last   = 1'b0;
        plan_mode   = mode_reg;
        plan_cur    = cur_reg;
        case (mode_reg)
            MODE_FIRST:
            begin
                if (target_reg == '0)
                begin
                    plan_emit = 1'b1;
                    plan_idx  = REG_CONTROL;
                    plan_val  = brake_word_reg;
                    plan_last = 1'b1;
                end
                else if (last_speed_reg == '0)
                begin
                    // Start from stop: release the brake, then ramp up.
                    plan_emit = 1'b1;
                    plan_idx  = REG_CONTROL;
                    plan_val  = run_word_reg;
                    plan_mode = MODE_RISE;
                end
                else if (target_reg < last_speed_reg)
                begin
                    plan_emit = 1'b1;
                    plan_val  = {1'b0, target_reg};
                    plan_last = 1'b1;
                end
                else if (target_reg > last_speed_reg)
                begin
                    plan_mode = MODE_RISE;
                end
                else
                begin
                    plan_finish = 1'b1;
                end
            end
            MODE_RISE:
            begin
                plan_mode = MODE_RAMP;
                if (last_speed_reg < start_speed_reg)
                begin
                    plan_emit = 1'b1;
                    plan_val  = {1'b0, jump_speed};
                    plan_last = (jump_speed == target_reg);
                    plan_cur  = jump_speed;
                end
                else
                begin
                    plan_cur = last_speed_reg;
                end
            end
            MODE_RAMP:
            begin
                plan_emit = 1'b1;
                plan_val  = {1'b0, ramp_next};
                plan_last = (ramp_next == target_reg);
                plan_cur  = ramp_next;
            end
            default:
            begin
                plan_finish = 1'b1;
            end
        endcase
    end

    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            S_IDLE:
            begin
                if (in_accept)
                    state_next = S_PLAN;
            end
            S_PLAN:
            begin
                if (plan_emit)
                    state_next = S_CRC;
                else if (plan_finish)
                    state_next = S_IDLE;
            end
            S_CRC:
            begin
                if (crc_done)
                    state_next = S_SEND;
            end
            S_SEND:
            begin
                if (out_accept)
                    state_next = frame_last_reg ? S_IDLE : S_PLAN;
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    // Configuration writes; indexes past the list are ignored.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            speed_limit_reg   <= RST_SPEED_LIMIT;
            start_speed_reg   <= RST_START_SPEED;
            ramp_step_reg     <= RST_RAMP_STEP;
            run_word_reg      <= RST_RUN_WORD;
            brake_word_reg    <= RST_BRAKE_WORD;
            slave_address_reg <= RST_SLAVE_ADDRESS;
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                CFG_SPEED_LIMIT:   speed_limit_reg   <= cfg_data[SPEED_W-1:0];
                CFG_START_SPEED:   start_speed_reg   <= cfg_data[SPEED_W-1:0];
                CFG_RAMP_STEP:     ramp_step_reg     <= cfg_data[STEP_W-1:0];
                CFG_RUN_WORD:      run_word_reg      <= cfg_data;
                CFG_BRAKE_WORD:    brake_word_reg    <= cfg_data;
                CFG_SLAVE_ADDRESS: slave_address_reg <= cfg_data[BYTE_W-1:0];
                default:           ;
            endcase
        end
    end

    // Control state and the kept speed.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= S_IDLE;
            mode_reg       <= MODE_FIRST;
            n_reg          <= '0;
            out_valid_reg  <= 1'b0;
            last_speed_reg <= '0;
            ramp_speed_reg <= '0;
        end
        else
        begin
            state_reg <= state_next;
            if (in_accept)
            begin
                mode_reg <= MODE_FIRST;
                n_reg    <= '0;
            end
            else if (state_reg == S_PLAN)
            begin
                mode_reg <= plan_mode;
                if (plan_emit)
                    n_reg <= n_reg + 1'b1;
            end
            if ((state_reg == S_CRC) && crc_done)
                out_valid_reg <= 1'b1;
            else if (out_accept)
                out_valid_reg <= 1'b0;
            // The kept speed only changes once the command is complete.
            if (out_accept && frame_last_reg)
                last_speed_reg <= target_reg;
            if (out_accept && (frame_idx_reg == REG_SPEED))
                ramp_speed_reg <= frame_val_reg;
        end
    end

    // Payload registers.
    always_ff @(posedge clk)
    begin
        if (in_accept)
            target_reg <= clamped;
        if (state_reg == S_PLAN)
            cur_reg <= plan_cur;
        if ((state_reg == S_PLAN) && plan_emit)
        begin
            frame_idx_reg  <= plan_idx;
            frame_val_reg  <= plan_val;
            frame_last_reg <= plan_last;
        end
        if ((state_reg == S_CRC) && crc_done)
            frame_crc_reg <= crc_value;
    end

    always_comb
    begin
        crc_req.start         = (state_reg == S_PLAN) && plan_emit;
        crc_req.slave_address = slave_address_reg;
        crc_req.reg_index     = plan_idx;
        crc_req.value         = plan_val;
    end

    srmfg_crc u_crc (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (crc_req),
        .done  (crc_done),
        .crc   (crc_value)
    );

    assign s_tready = (state_reg == S_IDLE);
    assign m_tvalid = out_valid_reg;
    assign m_tdata  = {frame_crc_reg, frame_val_reg, frame_idx_reg};
    assign m_tlast  = frame_last_reg;

    // A pending output word always keeps the input side closed.
    `ASSERT_IMPL(a_out_blocks_in, m_tvalid, !s_tready, "input ready while a word waits")
    // An accepted target always goes straight to planning.
    `ASSERT_NEXT(a_accept_plans, in_accept, state_reg == S_PLAN, "accept did not start planning")
    // The ramp never plans from a speed at or above the target.
    `ASSERT_IMPL(a_ramp_below, (state_reg == S_PLAN) && (mode_reg == MODE_RAMP),
                 cur_reg < target_reg, "ramp planned past the target")
    // The frame budget per command holds.
    `ASSERT_IMPL(a_frame_budget, 1'b1, n_reg <= FRAME_CNT_W'(MAX_FRAMES), "frame budget exceeded")
    // A command that ends on a speed frame leaves the ramp value equal to the kept speed.
    `ASSERT_NEXT(a_ramp_kept, out_accept && frame_last_reg && (frame_idx_reg == REG_SPEED),
                 ramp_speed_reg == WORD_W'(last_speed_reg), "ramp value differs from kept speed")

endmodule
